### src/bmsp_pkg.sv
// Shared types, codes and constants of the bracket modification sequence parser.
package bmsp_pkg;

	// Character classes decided by the front part
	localparam logic [2:0] CLS_UPPER = 3'd0;
	localparam logic [2:0] CLS_DIGIT = 3'd1;
	localparam logic [2:0] CLS_PLUS  = 3'd2;
	localparam logic [2:0] CLS_MINUS = 3'd3;
	localparam logic [2:0] CLS_POINT = 3'd4;
	localparam logic [2:0] CLS_OPEN  = 3'd5;
	localparam logic [2:0] CLS_CLOSE = 3'd6;
	localparam logic [2:0] CLS_OTHER = 3'd7;

	// Character codes
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// End status codes
	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_END_OK   = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR = 2'd2;
	localparam logic [1:0] ST_UNCLOSED = 2'd3;

	// Field widths fixed by the result format
	localparam int POS_W  = 13;
	localparam int MASS_W = 40;
	localparam int HALF_W = 20;
	localparam int POW_W  = 24;
	localparam int PP_W   = HALF_W + POW_W;
	localparam int WIDE_W = 64;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// One classified character as it travels through the queue
	typedef struct packed {
		logic [2:0] cls;
		logic [3:0] digit;
		logic       last;
	} char_item_t;

	// One finished step of the parser, handed to the scaling stages
	typedef struct packed {
		logic                  mod_valid;
		logic [MASS_W-1:0]     accum;
		logic [2:0]            shift;
		logic                  negative;
		logic                  overflowed;
		logic [POS_W-1:0]      pos;
		logic [1:0]            status;
	} parse_event_t;

	// Powers of ten used to scale a mass with few fractional digits
	function automatic logic [POW_W-1:0] pow_ten(input logic [2:0] sh);
		logic [POW_W-1:0] p;
		unique case (sh)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			3'd7: p = 24'd10000000;
			default: p = 24'd1;
		endcase
		return p;
	endfunction

endpackage

### src/bmsp_front.sv
// Front part: classifies each incoming character for the parser.
module bmsp_front (
	input  logic [7:0]           char_code,
	input  logic                 last_char,
	output bmsp_pkg::char_item_t item
);

	// Decide the class of the character and keep the digit value.
	// The low nibble of an ASCII digit is its value.
	always_comb begin
		item.last  = last_char;
		item.digit = char_code[3:0];
		if (char_code >= bmsp_pkg::CH_A && char_code <= bmsp_pkg::CH_Z) begin
			item.cls = bmsp_pkg::CLS_UPPER;
		end else if (char_code >= bmsp_pkg::CH_ZERO && char_code <= bmsp_pkg::CH_NINE) begin
			item.cls = bmsp_pkg::CLS_DIGIT;
		end else if (char_code == bmsp_pkg::CH_PLUS) begin
			item.cls = bmsp_pkg::CLS_PLUS;
		end else if (char_code == bmsp_pkg::CH_MINUS) begin
			item.cls = bmsp_pkg::CLS_MINUS;
		end else if (char_code == bmsp_pkg::CH_POINT) begin
			item.cls = bmsp_pkg::CLS_POINT;
		end else if (char_code == bmsp_pkg::CH_OPEN) begin
			item.cls = bmsp_pkg::CLS_OPEN;
		end else if (char_code == bmsp_pkg::CH_CLOSE) begin
			item.cls = bmsp_pkg::CLS_CLOSE;
		end else begin
			item.cls = bmsp_pkg::CLS_OTHER;
		end
	end

endmodule

### src/bmsp_queue.sv
// Short queue of classified characters between the front and back parts.
module bmsp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bmsp_pkg::char_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output bmsp_pkg::char_item_t head_item
);

	bmsp_pkg::char_item_t            entry_q [bmsp_pkg::QUEUE_DEPTH];
	logic [bmsp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bmsp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bmsp_pkg::QPTR_W:0]       count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full      = (count_q == (bmsp_pkg::QPTR_W + 1)'(bmsp_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_item = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### src/bmsp_back.sv
// Back part: the parser state machine that turns characters into events.
module bmsp_back #(
	parameter int MAX_RESIDUES = 4096,
	parameter int FRAC_DIGITS  = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   item_valid,
	input  bmsp_pkg::char_item_t   item,
	output logic                   pop,
	output logic                   event_vld_s1,
	output bmsp_pkg::parse_event_t event_s1
);

	localparam int CNT_W = $clog2(MAX_RESIDUES + 1);
	localparam int EXT_W = (CNT_W > bmsp_pkg::POS_W) ? CNT_W : bmsp_pkg::POS_W;
	localparam int ACC_T = bmsp_pkg::MASS_W + 4;
	localparam logic [ACC_T-1:0] MAG_LIMIT = ACC_T'(64'd1 << 39);

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_BRACKET = 2'd1;
	localparam logic [1:0] MODE_DISCARD = 2'd2;

	logic [1:0]                    mode_q,      mode_d;
	logic [CNT_W-1:0]              count_q,     count_d;
	logic [bmsp_pkg::MASS_W-1:0]   accum_q,     accum_d;
	logic                          negative_q,  negative_d;
	logic                          after_pt_q,  after_pt_d;
	logic [2:0]                    frac_q,      frac_d;
	logic                          stopped_q,   stopped_d;
	logic                          ovf_q,       ovf_d;
	logic                          started_q,   started_d;
	logic                          take;
	logic [ACC_T-1:0]              grown;
	logic [EXT_W-1:0]              count_ext;
	logic [EXT_W-1:0]              pos_full;
	bmsp_pkg::parse_event_t        ev;
	logic                          ev_out;

	assign pop       = advance && item_valid;
	assign count_ext = EXT_W'(count_q);
	assign pos_full  = (count_ext == '0) ? EXT_W'(1) : count_ext;
	assign grown     = (ACC_T'(accum_q) << 3) + (ACC_T'(accum_q) << 1) + ACC_T'(item.digit);

	// Next state of the parser for the character at the queue head.
	always_comb begin
		mode_d     = mode_q;
		count_d    = count_q;
		accum_d    = accum_q;
		negative_d = negative_q;
		after_pt_d = after_pt_q;
		frac_d     = frac_q;
		stopped_d  = stopped_q;
		ovf_d      = ovf_q;
		started_d  = started_q;
		take       = 1'b0;

		ev.mod_valid  = 1'b0;
		ev.accum      = accum_q;
		ev.shift      = 3'(FRAC_DIGITS) - frac_q;
		ev.negative   = negative_q;
		ev.overflowed = ovf_q;
		ev.pos        = pos_full[bmsp_pkg::POS_W-1:0];
		ev.status     = bmsp_pkg::ST_NONE;

		unique case (mode_q)
			MODE_NORMAL: begin
				unique case (item.cls)
					bmsp_pkg::CLS_UPPER: begin
						if (count_q < CNT_W'(MAX_RESIDUES)) begin
							count_d = count_q + 1'b1;
						end
					end
					bmsp_pkg::CLS_OPEN: begin
						mode_d     = MODE_BRACKET;
						accum_d    = '0;
						negative_d = 1'b0;
						after_pt_d = 1'b0;
						frac_d     = '0;
						stopped_d  = 1'b0;
						ovf_d      = 1'b0;
						started_d  = 1'b0;
					end
					bmsp_pkg::CLS_CLOSE, bmsp_pkg::CLS_POINT, bmsp_pkg::CLS_DIGIT: begin
					end
					default: begin
						mode_d    = MODE_DISCARD;
						ev.status = bmsp_pkg::ST_BAD_CHAR;
					end
				endcase
			end
			MODE_BRACKET: begin
				if (item.cls == bmsp_pkg::CLS_CLOSE) begin
					ev.mod_valid = 1'b1;
					mode_d       = MODE_NORMAL;
					accum_d      = '0;
					negative_d   = 1'b0;
					after_pt_d   = 1'b0;
					frac_d       = '0;
					stopped_d    = 1'b0;
					ovf_d        = 1'b0;
					started_d    = 1'b0;
				end else if (!stopped_q) begin
					priority if (item.cls == bmsp_pkg::CLS_DIGIT) begin
						started_d = 1'b1;
						if (!after_pt_q) begin
							take = 1'b1;
						end else if (frac_q < 3'(FRAC_DIGITS)) begin
							take   = 1'b1;
							frac_d = frac_q + 1'b1;
						end
					end else if ((item.cls == bmsp_pkg::CLS_PLUS ||
						      item.cls == bmsp_pkg::CLS_MINUS) && !started_q) begin
						started_d  = 1'b1;
						negative_d = (item.cls == bmsp_pkg::CLS_MINUS);
					end else if (item.cls == bmsp_pkg::CLS_POINT && !after_pt_q) begin
						started_d  = 1'b1;
						after_pt_d = 1'b1;
					end else begin
						stopped_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// Multiply-add by ten, clamped once the magnitude passes the limit.
		if (take && !ovf_q) begin
			if (grown > MAG_LIMIT) begin
				ovf_d   = 1'b1;
				accum_d = MAG_LIMIT[bmsp_pkg::MASS_W-1:0];
			end else begin
				accum_d = grown[bmsp_pkg::MASS_W-1:0];
			end
		end

		// The last character of a sequence closes it and resets the parser.
		if (item.last) begin
			if (mode_q != MODE_DISCARD && ev.status == bmsp_pkg::ST_NONE) begin
				ev.status = (mode_d == MODE_BRACKET) ? bmsp_pkg::ST_UNCLOSED
								     : bmsp_pkg::ST_END_OK;
			end
			mode_d     = MODE_NORMAL;
			count_d    = '0;
			accum_d    = '0;
			negative_d = 1'b0;
			after_pt_d = 1'b0;
			frac_d     = '0;
			stopped_d  = 1'b0;
			ovf_d      = 1'b0;
			started_d  = 1'b0;
		end

		ev_out = ev.mod_valid || (ev.status != bmsp_pkg::ST_NONE);
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			count_q    <= '0;
			accum_q    <= '0;
			negative_q <= 1'b0;
			after_pt_q <= 1'b0;
			frac_q     <= '0;
			stopped_q  <= 1'b0;
			ovf_q      <= 1'b0;
			started_q  <= 1'b0;
		end else if (pop) begin
			mode_q     <= mode_d;
			count_q    <= count_d;
			accum_q    <= accum_d;
			negative_q <= negative_d;
			after_pt_q <= after_pt_d;
			frac_q     <= frac_d;
			stopped_q  <= stopped_d;
			ovf_q      <= ovf_d;
			started_q  <= started_d;
		end
	end

	// Event stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_vld_s1 <= 1'b0;
		end else if (advance) begin
			event_vld_s1 <= pop && ev_out;
		end
	end

	// Event stage payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			event_s1 <= ev;
		end
	end

endmodule

### src/bmsp_scale.sv
// Mass scaling, clamping and the output register of the result channel.
module bmsp_scale (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   event_vld_s1,
	input  bmsp_pkg::parse_event_t event_s1,
	output logic                   out_vld_q,
	output logic                   mod_valid_q,
	output logic [12:0]            residue_pos_q,
	output logic [39:0]            mass_micro_q,
	output logic                   mass_sat_q,
	output logic [1:0]             status_q
);

	localparam int W  = bmsp_pkg::WIDE_W;
	localparam int HW = bmsp_pkg::HALF_W;
	localparam logic [W-1:0] LIMIT_NEG = W'(64'd1 << 39);
	localparam logic [W-1:0] LIMIT_POS = W'((64'd1 << 39) - 64'd1);

	logic                          vld_s2;
	logic [bmsp_pkg::PP_W-1:0]     pp_hi_s2;
	logic [bmsp_pkg::PP_W-1:0]     pp_lo_s2;
	logic                          mod_valid_s2;
	logic                          negative_s2;
	logic                          ovf_s2;
	logic [bmsp_pkg::POS_W-1:0]    pos_s2;
	logic [1:0]                    status_s2;
	logic [bmsp_pkg::POW_W-1:0]    factor;
	logic [W-1:0]                  scaled;
	logic [W-1:0]                  limit;
	logic                          sat;
	logic [bmsp_pkg::MASS_W-1:0]   mag;
	logic [bmsp_pkg::MASS_W-1:0]   mass;

	assign factor = bmsp_pkg::pow_ten(event_s1.shift);

	// Partial products stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= event_vld_s1;
		end
	end

	// Two half-width partial products of the scaling multiplication.
	always_ff @(posedge clk) begin
		if (advance) begin
			pp_hi_s2     <= event_s1.accum[bmsp_pkg::MASS_W-1:HW] * factor;
			pp_lo_s2     <= event_s1.accum[HW-1:0] * factor;
			mod_valid_s2 <= event_s1.mod_valid;
			negative_s2  <= event_s1.negative;
			ovf_s2       <= event_s1.overflowed;
			pos_s2       <= event_s1.pos;
			status_s2    <= event_s1.status;
		end
	end

	// Sum the partial products, clamp to the signed range and apply the sign.
	always_comb begin
		scaled = (W'(pp_hi_s2) << HW) + W'(pp_lo_s2);
		limit  = negative_s2 ? LIMIT_NEG : LIMIT_POS;
		sat    = ovf_s2 || (scaled > limit);
		mag    = sat ? limit[bmsp_pkg::MASS_W-1:0] : scaled[bmsp_pkg::MASS_W-1:0];
		mass   = negative_s2 ? (bmsp_pkg::MASS_W'(0) - mag) : mag;
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s2;
		end
	end

	// Output register payload; fields of a missing modification read as zero.
	always_ff @(posedge clk) begin
		if (advance) begin
			mod_valid_q   <= mod_valid_s2;
			residue_pos_q <= mod_valid_s2 ? pos_s2 : '0;
			mass_micro_q  <= mod_valid_s2 ? mass : '0;
			mass_sat_q    <= mod_valid_s2 && sat;
			status_q      <= status_s2;
		end
	end

endmodule

### src/bracket_mod_sequence_parser_unit.sv
// Top level of the bracket modification sequence parser.
// Throughput: one character per cycle while the result side keeps taking transfers.
// After its character is accepted, a result passes through the queue slot feeding the parser
// event stage, the partial product stage and the output register.
// A stalled result side holds the pipeline; the four-entry queue then fills and
// s_axis_tready falls. Reset (arst_n low) clears the queue, the parser and the valid flags.
module bracket_mod_sequence_parser_unit #(
	parameter int MAX_RESIDUES = 4096,
	parameter int FRAC_DIGITS  = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  logic        s_axis_tlast,  // last_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [12:0] residue_pos, [52:13] mass_micro,
	                                   // [53] mass_saturated, [55:54] status
	output logic        m_axis_tuser   // mod_valid
);

	bmsp_pkg::char_item_t   front_item;
	bmsp_pkg::char_item_t   head_item;
	bmsp_pkg::parse_event_t event_s1;
	logic                   q_full;
	logic                   q_not_empty;
	logic                   pop;
	logic                   advance;
	logic                   event_vld_s1;
	logic                   out_vld_q;
	logic                   mod_valid_q;
	logic [12:0]            residue_pos_q;
	logic [39:0]            mass_micro_q;
	logic                   mass_sat_q;
	logic [1:0]             status_q;

	// The back pipeline moves whenever the output register is free or being emptied.
	assign advance       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !q_full;

	bmsp_front u_front (
		.char_code (s_axis_tdata),
		.last_char (s_axis_tlast),
		.item      (front_item)
	);

	bmsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_axis_tvalid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	bmsp_back #(
		.MAX_RESIDUES (MAX_RESIDUES),
		.FRAC_DIGITS  (FRAC_DIGITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item_valid   (q_not_empty),
		.item         (head_item),
		.pop          (pop),
		.event_vld_s1 (event_vld_s1),
		.event_s1     (event_s1)
	);

	bmsp_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.event_vld_s1  (event_vld_s1),
		.event_s1      (event_s1),
		.out_vld_q     (out_vld_q),
		.mod_valid_q   (mod_valid_q),
		.residue_pos_q (residue_pos_q),
		.mass_micro_q  (mass_micro_q),
		.mass_sat_q    (mass_sat_q),
		.status_q      (status_q)
	);

	// Result transfer packing.
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = mod_valid_q;
	assign m_axis_tdata  = {status_q, mass_sat_q, mass_micro_q, residue_pos_q};

endmodule
